// ----- rtl/core/sstf_pkg.sv -----
`default_nettype none

package sstf_pkg;

    localparam int TRACK_W = 16;
    localparam int TOTAL_W = 22;
    localparam int SCOUNT_W = 7;

    // Operation codes on the request channel
    localparam logic OP_SET_HEAD = 1'b0;
    localparam logic OP_ADD_REQ  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    // Candidate handed from cell to cell during a scan
    typedef struct packed {
        logic               found;
        logic [TRACK_W-1:0] seek;
        logic [TRACK_W-1:0] track;
    } t_cand;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic               load;
        logic               clear;
        logic [TRACK_W-1:0] head;
        logic [TRACK_W-1:0] data;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- rtl/core/sstf_req_if.sv -----
`default_nettype none

interface sstf_req_if;
    import sstf_pkg::*;

    logic               valid;
    logic               ready;
    logic               operation;
    logic [TRACK_W-1:0] track;
    logic               last;

    modport source (output valid, output operation, output track, output last, input ready);
    modport sink   (input valid, input operation, input track, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sstf_res_if.sv -----
`default_nettype none

interface sstf_res_if;
    import sstf_pkg::*;

    logic                valid;
    logic                ready;
    logic [TRACK_W-1:0]  served_track;
    logic [TRACK_W-1:0]  seek_distance;
    logic [TOTAL_W-1:0]  total_distance;
    logic [SCOUNT_W-1:0] served_count;
    logic                run_last;
    logic                requests_dropped;

    modport source (output valid, output served_track, output seek_distance,
                    output total_distance, output served_count, output run_last,
                    output requests_dropped, input ready);
    modport sink   (input valid, input served_track, input seek_distance,
                    input total_distance, input served_count, input run_last,
                    input requests_dropped, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sstf_cell.sv -----
`default_nettype none

module sstf_cell
    import sstf_pkg::*;
#(
    parameter int IDX_W    = 6,
    parameter int CELL_IDX = 0
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cell_ctl        i_ctl,
    input  wire logic [IDX_W-1:0] i_wr_idx,
    input  wire logic [IDX_W-1:0] i_clr_idx,
    input  wire t_cand            i_cand,
    input  wire logic [IDX_W-1:0] i_cand_idx,
    output t_cand                 o_cand,
    output logic [IDX_W-1:0]      o_cand_idx
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [TRACK_W-1:0] r_track;
    logic               r_pending;
    logic               r_found;
    logic [TRACK_W-1:0] r_best_seek;
    logic [TRACK_W-1:0] r_best_track;
    logic [IDX_W-1:0]   r_cand_idx;

    logic [TRACK_W-1:0] seek;
    logic               take;
    t_cand              n_cand;
    logic [IDX_W-1:0]   n_cand_idx;
    logic               n_pending;

    always_comb begin
        seek = (i_ctl.head >= r_track) ? (i_ctl.head - r_track) : (r_track - i_ctl.head);
        // strict compare: an earlier slot wins a tie
        take = r_pending && (!i_cand.found || (seek < i_cand.seek));
        if (take) begin
            n_cand.found = 1'b1;
            n_cand.seek  = seek;
            n_cand.track = r_track;
            n_cand_idx   = MY_IDX;
        end else begin
            n_cand     = i_cand;
            n_cand_idx = i_cand_idx;
        end
        n_pending = r_pending;
        if (i_ctl.clear && (i_clr_idx == MY_IDX)) begin
            n_pending = 1'b0;
        end
        if (i_ctl.load && (i_wr_idx == MY_IDX)) begin
            n_pending = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            r_pending <= n_pending;
            r_found   <= n_cand.found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && (i_wr_idx == MY_IDX)) begin
            r_track <= i_ctl.data;
        end
        r_best_seek  <= n_cand.seek;
        r_best_track <= n_cand.track;
        r_cand_idx   <= n_cand_idx;
    end

    assign o_cand.found = r_found;
    assign o_cand.seek  = r_best_seek;
    assign o_cand.track = r_best_track;
    assign o_cand_idx   = r_cand_idx;

endmodule

`default_nettype wire

// ----- rtl/core/sstf_disk_scheduler.sv -----
// Channel   Dir  Words carried
// i_req     in   operation (set head / add request), track, last
// o_res     out  served_track, seek_distance, total_distance, served_count,
//                run_last, requests_dropped
//
// Each request word is taken while the scheduler is idle.
// After the word with last, each served word costs a scan that steps through
// every cell of the row, followed by an emit step, and the run repeats this
// for each request of the batch.
// i_req.ready stays low during the service run. A result waits in the output
// register while o_res.ready is low; the run holds in its emit step meanwhile.
// Reset (i_rst_n low, synchronous) empties the queue and puts the head at zero.
`default_nettype none

module sstf_disk_scheduler
    import sstf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sstf_req_if.sink    i_req,
    sstf_res_if.source  o_res
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] SCAN_END  = IDX_W'(QUEUE_DEPTH - 1);

    t_state r_state, n_state;

    // batch and head state
    logic [TRACK_W-1:0] r_head, n_head;
    logic [CNT_W-1:0]   r_loaded, n_loaded;
    logic [CNT_W-1:0]   r_served, n_served;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic               r_overflow, n_overflow;
    logic [IDX_W-1:0]   r_scan, n_scan;

    // output register
    logic                r_out_valid, n_out_valid;
    logic [TRACK_W-1:0]  r_out_track, n_out_track;
    logic [TRACK_W-1:0]  r_out_dist, n_out_dist;
    logic [TOTAL_W-1:0]  r_out_total, n_out_total;
    logic [SCOUNT_W-1:0] r_out_count, n_out_count;
    logic                r_out_last, n_out_last;
    logic                r_out_drop, n_out_drop;

    logic               req_take;
    logic               out_free;
    logic               room;
    logic [CNT_W-1:0]   loaded_after;
    logic [CNT_W-1:0]   served_inc;
    logic               emit_go;
    logic               batch_done;
    t_cell_ctl          cell_ctl;

    // row of cells: candidate enters at cell 0 empty and leaves cell QUEUE_DEPTH-1
    t_cand              cand   [QUEUE_DEPTH+1];
    logic [IDX_W-1:0]   cand_i [QUEUE_DEPTH+1];
    t_cand              win;
    logic [IDX_W-1:0]   win_idx;

    assign cand[0]   = '0;
    assign cand_i[0] = '0;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        sstf_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (cell_ctl),
            .i_wr_idx   (r_loaded[IDX_W-1:0]),
            .i_clr_idx  (win_idx),
            .i_cand     (cand[g]),
            .i_cand_idx (cand_i[g]),
            .o_cand     (cand[g+1]),
            .o_cand_idx (cand_i[g+1])
        );
    end

    // The candidate stream is re-injected every cycle; head and pending bits
    // hold during scan and emit-wait, so the row's exit carries the same winner.
    assign win     = cand[QUEUE_DEPTH];
    assign win_idx = cand_i[QUEUE_DEPTH];

    assign req_take     = i_req.valid && (r_state == ST_IDLE);
    assign out_free     = !r_out_valid || o_res.ready;
    assign room         = (r_loaded < DEPTH_CNT);
    assign loaded_after = ((i_req.operation == OP_ADD_REQ) && room) ? (r_loaded + 1'b1)
                                                                    : r_loaded;
    assign served_inc   = r_served + 1'b1;
    assign emit_go      = (r_state == ST_EMIT) && out_free;
    assign batch_done   = (served_inc == r_loaded);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (req_take && i_req.last && (loaded_after != '0)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_scan == SCAN_END) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = batch_done ? ST_IDLE : ST_SCAN;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath and controls
    always_comb begin
        n_head      = r_head;
        n_loaded    = r_loaded;
        n_served    = r_served;
        n_total     = r_total;
        n_overflow  = r_overflow;
        n_scan      = '0;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_track = r_out_track;
        n_out_dist  = r_out_dist;
        n_out_total = r_out_total;
        n_out_count = r_out_count;
        n_out_last  = r_out_last;
        n_out_drop  = r_out_drop;

        cell_ctl.load  = 1'b0;
        cell_ctl.clear = 1'b0;
        cell_ctl.head  = r_head;
        cell_ctl.data  = i_req.track;

        case (r_state)
            ST_IDLE: begin
                if (req_take) begin
                    if (i_req.operation == OP_SET_HEAD) begin
                        n_head = i_req.track;
                    end else if (room) begin
                        cell_ctl.load = 1'b1;
                    end else begin
                        n_overflow = 1'b1;
                    end
                    n_loaded = loaded_after;
                    n_served = '0;
                    n_total  = '0;
                    // empty batch: drop the flag, nothing to serve
                    if (i_req.last && (loaded_after == '0)) begin
                        n_overflow = 1'b0;
                    end
                end
            end
            ST_SCAN: begin
                n_scan = r_scan + 1'b1;
            end
            ST_EMIT: begin
                if (emit_go) begin
                    cell_ctl.clear = 1'b1;
                    n_head      = win.track;
                    n_total     = r_total + TOTAL_W'(win.seek);
                    n_served    = served_inc;
                    n_out_valid = 1'b1;
                    n_out_track = win.track;
                    n_out_dist  = win.seek;
                    n_out_total = r_total + TOTAL_W'(win.seek);
                    n_out_count = SCOUNT_W'(served_inc);
                    n_out_last  = batch_done;
                    n_out_drop  = r_overflow;
                    if (batch_done) begin
                        n_loaded   = '0;
                        n_overflow = 1'b0;
                    end
                end
            end
            default: begin
                n_scan = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_loaded    <= '0;
            r_served    <= '0;
            r_total     <= '0;
            r_overflow  <= 1'b0;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_loaded    <= n_loaded;
            r_served    <= n_served;
            r_total     <= n_total;
            r_overflow  <= n_overflow;
            r_scan      <= n_scan;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_track <= n_out_track;
        r_out_dist  <= n_out_dist;
        r_out_total <= n_out_total;
        r_out_count <= n_out_count;
        r_out_last  <= n_out_last;
        r_out_drop  <= n_out_drop;
    end

    assign i_req.ready            = (r_state == ST_IDLE);
    assign o_res.valid            = r_out_valid;
    assign o_res.served_track     = r_out_track;
    assign o_res.seek_distance    = r_out_dist;
    assign o_res.total_distance   = r_out_total;
    assign o_res.served_count     = r_out_count;
    assign o_res.run_last         = r_out_last;
    assign o_res.requests_dropped = r_out_drop;

endmodule

`default_nettype wire
